/* sv/plkt_pkg.sv */
// Package for the parent linked key table: payload structs, status codes,
// opcodes and sizing constants. No dependencies.
package plkt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LIM_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOPARENT = 3'd3,
        ST_HASKIDS  = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_NOKIDS   = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] parent_key;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] child_key;
        logic        last;
    } out_item_t;

    // Data moving along the chain of cells, one slot per cell.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] parent;
    } entry_t;

endpackage

/* sv/plkt_cell.sv */
// One cell of the table chain: holds one entry and takes its neighbor's entry
// when the chain rotates. Depends on plkt_pkg.
module plkt_cell
    import plkt_pkg::*;
(
    input  logic   clk,
    input  logic   shift,     // rotate: take entry from neighbor
    input  logic   load,      // overwrite with load_data
    input  entry_t load_data,
    input  entry_t prev,
    output entry_t value
);

    entry_t value_reg;

    // Hold, rotate or load the stored entry
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= load_data;
        end
        else if (shift)
        begin
            value_reg <= prev;
        end
    end

    assign value = value_reg;

endmodule

/* sv/parent_linked_key_table_unit.sv */
// Top level of the parent linked key table: a ring of plkt_cell stages scanned
// by a sequencer. Depends on plkt_pkg and plkt_cell.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | in_item_t  (op, key, parent_key)
//  out     | out | out_valid/out_ready| out_item_t (status, child_key, last)
//  cfg     | in  | cfg_valid/cfg_ready| table_limit (7 bits)
//
// An item is accepted in S_IDLE, then scanned in S_SCAN while the ring rotates
// once so every slot passes cell 0, then committed in S_COMMIT. Finds emit one
// result per matching entry, the last at commit with last set; the scan stalls on
// a match while a held result and a full out buffer wait. Reset clears the count
// and sets the limit to 64; entry contents are not cleared.
module parent_linked_key_table_unit
    import plkt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LIM_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    in_item_t         item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [LIM_W-1:0] limit_reg;
    logic [IDX_W-1:0] step_reg;      // slot at cell 0 during scan
    logic             dup_reg, par_reg, kids_reg, found_reg, any_reg;
    logic [IDX_W-1:0] slot_reg;
    entry_t           tail_ent_reg;       // last stored entry, caught as it passes cell 0
    logic             pend_valid_reg;     // held find result, awaiting next match
    out_item_t        pend_reg;
    logic             obuf_valid_reg;
    out_item_t        obuf_reg;

    entry_t cells [CAPACITY];
    logic   shift;
    logic   load_any;
    logic [IDX_W-1:0] load_idx;
    entry_t load_data;
    entry_t head;
    logic   in_range;
    logic   stall;
    logic   emit_ok;
    logic   commit_out;
    out_item_t commit_item;
    logic [CNT_W-1:0] lim_eff;
    logic [IDX_W-1:0] tail;
    logic   commit_ins, commit_del;

    assign head     = cells[0];
    assign in_range = {1'b0, step_reg} < count_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign tail      = IDX_W'(count_reg - CNT_W'(1));

    // Effective limit clipped to capacity
    always_comb
    begin
        if (limit_reg > LIM_W'(CAPACITY))
            lim_eff = CNT_W'(CAPACITY);
        else
            lim_eff = CNT_W'(limit_reg);
    end

    // A new find match needs the held one moved into the output buffer
    assign emit_ok = !pend_valid_reg || !obuf_valid_reg || out_ready;
    assign stall   = (state_reg == S_SCAN) && (item_reg.op == OP_FIND) && in_range
                     && (head.parent == item_reg.parent_key) && !emit_ok;
    assign shift   = (state_reg == S_SCAN) && !stall;

    // Commit decision and result
    always_comb
    begin
        commit_ins  = 1'b0;
        commit_del  = 1'b0;
        commit_item = '{status: ST_OK, child_key: 32'd0, last: 1'b1};
        case (item_reg.op)
            OP_INSERT:
            begin
                if (count_reg >= lim_eff)
                    commit_item.status = ST_FULL;
                else if (dup_reg)
                    commit_item.status = ST_DUP;
                else if (item_reg.parent_key != 32'd0 && !par_reg)
                    commit_item.status = ST_NOPARENT;
                else
                    commit_ins = 1'b1;
            end
            OP_DELETE:
            begin
                if (kids_reg)
                    commit_item.status = ST_HASKIDS;
                else if (!found_reg)
                    commit_item.status = ST_NOTFOUND;
                else
                    commit_del = 1'b1;
            end
            OP_FIND:
            begin
                if (any_reg)
                    commit_item = pend_reg;
                else
                    commit_item.status = ST_NOKIDS;
                commit_item.last = 1'b1;
            end
            default:
            begin
                commit_item = '{status: ST_OK, child_key: 32'd0, last: 1'b1};
            end
        endcase
    end

    // Commit can issue only when the buffer is free
    assign commit_out = (state_reg == S_COMMIT) && (item_reg.op != OP_NONE)
                        && (!obuf_valid_reg || out_ready);

    // Loads into the ring happen at commit, after a full rotation
    always_comb
    begin
        load_any  = 1'b0;
        load_idx  = '0;
        load_data = tail_ent_reg;
        if (state_reg == S_COMMIT && commit_out)
        begin
            if (commit_ins)
            begin
                load_any  = 1'b1;
                load_idx  = IDX_W'(count_reg);
                load_data = '{key: item_reg.key, parent: item_reg.parent_key};
            end
            else if (commit_del)
            begin
                load_any = 1'b1;
                load_idx = slot_reg;
            end
        end
    end

    // Ring of cells; cell i takes cell i+1 so slots pass cell 0 in order
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            plkt_cell u_cell (
                .clk       (clk),
                .shift     (shift),
                .load      (load_any && load_idx == IDX_W'(g)),
                .load_data (load_data),
                .prev      (cells[(g + 1) % CAPACITY]),
                .value     (cells[g])
            );
        end
    endgenerate

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (shift && step_reg == IDX_W'(CAPACITY - 1))
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (item_reg.op == OP_NONE || commit_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            limit_reg      <= LIM_W'(64);
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            obuf_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (state_reg == S_IDLE && in_valid)
                step_reg <= '0;
            else if (shift)
                step_reg <= step_reg + IDX_W'(1);
            if (commit_out && commit_ins)
                count_reg <= count_reg + CNT_W'(1);
            else if (commit_out && commit_del)
                count_reg <= count_reg - CNT_W'(1);
            // Output buffer: commit, then find matches, else drain
            if (commit_out)
            begin
                obuf_valid_reg <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (shift && item_reg.op == OP_FIND && in_range
                     && head.parent == item_reg.parent_key)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                    obuf_valid_reg <= 1'b1;
                else if (out_ready)
                    obuf_valid_reg <= 1'b0;
            end
            else if (out_ready)
            begin
                obuf_valid_reg <= 1'b0;
            end
        end
    end

    // Scan flags and payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg  <= in_data;
            dup_reg   <= 1'b0;
            par_reg   <= 1'b0;
            kids_reg  <= 1'b0;
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        else if (shift && in_range)
        begin
            // Catch the last stored entry for a delete's move
            if (step_reg == tail)
                tail_ent_reg <= head;
            if (head.key == item_reg.key)
            begin
                dup_reg   <= 1'b1;
                found_reg <= 1'b1;
                slot_reg  <= step_reg;
            end
            if (head.key == item_reg.parent_key)
                par_reg <= 1'b1;
            if (head.parent == item_reg.key)
                kids_reg <= 1'b1;
            if (item_reg.op == OP_FIND && head.parent == item_reg.parent_key)
            begin
                any_reg  <= 1'b1;
                pend_reg <= '{status: ST_OK, child_key: head.key, last: 1'b0};
                if (pend_valid_reg)
                    obuf_reg <= pend_reg;
            end
        end
        if (commit_out)
            obuf_reg <= commit_item;
    end

    assign out_valid = obuf_valid_reg;
    assign out_data  = obuf_reg;

    // Count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Input is taken only while idle
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> state_reg == S_IDLE)
        else $error("input transfer outside idle");

    // Count changes only on a commit
    a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_COMMIT) |=> $stable(count_reg))
        else $error("count changed outside commit");

    // Held output is not overwritten while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output dropped while stalled");

endmodule
